/* design/mm2_pkg.sv */
// Package for the MurmurHash2 string hasher: payload types, codes and constants.
package mm2_pkg;

    localparam int LEN_W = 13;

    localparam logic [31:0] MIX_MUL     = 32'h5BD1_E995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;
    localparam logic [31:0] SEED_RESET  = 32'h3141_5926;
    localparam logic [LEN_W-1:0] COUNT_MAX = {LEN_W{1'b1}};

    // configuration register indexes
    localparam logic CFG_SEED = 1'b0;
    localparam logic CFG_FOLD = 1'b1;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] total_length;
        logic             last_byte;
    } in_t;

    typedef struct packed {
        logic [31:0] hash_value;
        logic        length_error;
    } out_t;

endpackage

/* design/mm2_mul.sv */
// Shared multiplier: registered low 32 bits of operand times the mix constant.
module mm2_mul (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] a,
    output logic [31:0] p
);

    logic [31:0] p_reg;

    // product holds while en is low
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= a * mm2_pkg::MIX_MUL;
        end
    end

    assign p = p_reg;

endmodule

/* design/murmur2_string_hash.sv */
// Top level of the MurmurHash2 string hasher: byte packer, sequencer and output register.
//
// Hashes a string fed one byte per transfer (declared length on every byte, last_byte on
// the final one) and returns one result transfer per string: the 32-bit MurmurHash2 and
// a flag set when the byte count does not match the declared length or that length lies
// outside 1..MAX_LENGTH. The first, second and third byte of each four-byte group are packed
// into the word register. The fourth byte holds s_ready low while the word mix runs as four
// steps (ST_K1, ST_K2, ST_H, ST_X) through the single shared 32x32 multiplier. A final byte
// adds the finalizer states (ST_T, ST_T2 only when a one- to three-byte tail is pending,
// ST_F1, ST_F2), plus any wait for the output register to drain. The output register lets a
// result sit while the next string's bytes stream in. seed and fold_case are written over the
// cfg_ port, which is always ready; seed applies from the next string start, fold_case
// from the next byte.
module murmur2_string_hash #(
    parameter int MAX_LENGTH = 4096
) (
    input  logic          aclk,
    input  logic          aresetn,
    // byte input
    input  logic          s_valid,
    output logic          s_ready,
    input  mm2_pkg::in_t  s_data,
    // result output
    output logic          m_valid,
    input  logic          m_ready,
    output mm2_pkg::out_t m_data,
    // configuration writes
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [31:0]   cfg_data
);

    localparam int LW = mm2_pkg::LEN_W;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_K1   = 9'b000000010,  // k * M
        ST_K2   = 9'b000000100,  // (k ^ k >> 24) * M
        ST_H    = 9'b000001000,  // h * M
        ST_X    = 9'b000010000,  // h = h*M ^ k
        ST_T    = 9'b000100000,  // tail xor and multiply
        ST_T2   = 9'b001000000,
        ST_F1   = 9'b010000000,  // (h ^ h >> 13) * M
        ST_F2   = 9'b100000000   // h ^ h >> 15 into output register
    } state_t;

    state_t         state_reg, state_next;

    // configuration
    logic [31:0]    seed_reg;
    logic           fold_reg;

    // string state
    logic [31:0]    hash_reg, hash_next;
    logic [31:0]    k_reg, k_next;
    logic [23:0]    word_reg, word_next;
    logic [1:0]     slot_reg, slot_next;
    logic [LW-1:0]  count_reg, count_next;
    logic           open_reg, open_next;
    logic           last_reg, last_next;
    logic           err_reg, err_next;

    // output register
    logic           m_valid_reg, m_valid_next;
    mm2_pkg::out_t  m_data_reg, m_data_next;

    // shared multiplier
    logic           mul_en;
    logic [31:0]    mul_a;
    logic [31:0]    mul_p;

    // per-byte values
    logic           s_fire;
    logic [7:0]     byte_f;
    logic [23:0]    word_base;
    logic [1:0]     slot_base;
    logic [LW-1:0]  count_base, count_inc;
    logic [31:0]    hash_base;
    logic [31:0]    fin_hash;
    logic           out_free;

    mm2_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .p    (mul_p)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    // a byte taken with no string open starts a fresh one
    assign word_base  = open_reg ? word_reg  : 24'h0;
    assign slot_base  = open_reg ? slot_reg  : 2'd0;
    assign count_base = open_reg ? count_reg : '0;
    assign hash_base  = open_reg ? hash_reg  : (seed_reg ^ 32'(s_data.total_length));
    assign count_inc  = (count_base < mm2_pkg::COUNT_MAX) ? count_base + 1'b1 : count_base;

    always_comb begin
        byte_f = s_data.data_byte;
        if (fold_reg && s_data.data_byte >= 8'h41 && s_data.data_byte <= 8'h5A) begin
            byte_f = s_data.data_byte + 8'h20;
        end
    end

    assign fin_hash = mul_p ^ (mul_p >> mm2_pkg::FIN_SHIFT_B);

    // multiplier operand select
    always_comb begin
        mul_en = 1'b0;
        mul_a  = hash_reg;
        unique case (state_reg)
            ST_K1: begin
                mul_en = 1'b1;
                mul_a  = k_reg;
            end
            ST_K2: begin
                mul_en = 1'b1;
                mul_a  = mul_p ^ (mul_p >> mm2_pkg::MIX_SHIFT);
            end
            ST_H: begin
                mul_en = 1'b1;
                mul_a  = hash_reg;
            end
            ST_T: begin
                mul_en = (slot_reg != 2'd0);
                mul_a  = hash_reg ^ {8'h00, word_reg};
            end
            ST_F1: begin
                mul_en = 1'b1;
                mul_a  = hash_reg ^ (hash_reg >> mm2_pkg::FIN_SHIFT_A);
            end
            default: begin
                mul_en = 1'b0;
                mul_a  = hash_reg;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        hash_next    = hash_reg;
        k_next       = k_reg;
        word_next    = word_reg;
        slot_next    = slot_reg;
        count_next   = count_reg;
        open_next    = open_reg;
        last_next    = last_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    open_next  = 1'b1;
                    hash_next  = hash_base;
                    count_next = count_inc;
                    last_next  = s_data.last_byte;
                    err_next   = (count_inc != s_data.total_length)
                                 || (s_data.total_length == '0)
                                 || (32'(s_data.total_length) > 32'(MAX_LENGTH));
                    if (slot_base == 2'd3) begin
                        k_next     = {byte_f, word_base};
                        word_next  = 24'h0;
                        slot_next  = 2'd0;
                        state_next = ST_K1;
                    end else begin
                        case (slot_base)
                            2'd0:    word_next = {word_base[23:8], byte_f};
                            2'd1:    word_next = {word_base[23:16], byte_f, word_base[7:0]};
                            default: word_next = {byte_f, word_base[15:0]};
                        endcase
                        slot_next  = slot_base + 2'd1;
                        state_next = s_data.last_byte ? ST_T : ST_IDLE;
                    end
                end
            end
            ST_K1: state_next = ST_K2;
            ST_K2: state_next = ST_H;
            ST_H: begin
                k_next     = mul_p;
                state_next = ST_X;
            end
            ST_X: begin
                hash_next  = mul_p ^ k_reg;
                state_next = last_reg ? ST_T : ST_IDLE;
            end
            ST_T: state_next = (slot_reg != 2'd0) ? ST_T2 : ST_F1;
            ST_T2: begin
                hash_next  = mul_p;
                state_next = ST_F1;
            end
            ST_F1: state_next = ST_F2;
            ST_F2: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.hash_value   = fin_hash;
                    m_data_next.length_error = err_reg;
                    open_next                = 1'b0;
                    word_next                = 24'h0;
                    slot_next                = 2'd0;
                    count_next               = '0;
                    hash_next                = 32'h0;
                    state_next               = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            seed_reg    <= mm2_pkg::SEED_RESET;
            fold_reg    <= 1'b1;
            hash_reg    <= 32'h0;
            word_reg    <= 24'h0;
            slot_reg    <= 2'd0;
            count_reg   <= '0;
            open_reg    <= 1'b0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hash_reg    <= hash_next;
            word_reg    <= word_next;
            slot_reg    <= slot_next;
            count_reg   <= count_next;
            open_reg    <= open_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    mm2_pkg::CFG_SEED: seed_reg <= cfg_data;
                    mm2_pkg::CFG_FOLD: fold_reg <= cfg_data[0];
                    default:           seed_reg <= seed_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        k_reg      <= k_next;
        err_reg    <= err_next;
        m_data_reg <= m_data_next;
    end

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the MurmurHash2 string hasher: stimulus, prediction and checks.
`timescale 1ns / 1ps

module tb_top;

    // Tracks one string at a time as the bytes are accepted. It keeps the expected result of
    // every closed string in order and compares each result transfer against the oldest.
    class hash_ledger;
        localparam int MAX_LEN = 4096;

        logic [31:0]               seed_q;
        logic                      fold_q;
        logic [31:0]               acc;
        logic [23:0]               pend;
        logic [1:0]                slot;
        logic [mm2_pkg::LEN_W-1:0] count;
        bit                        in_str;
        mm2_pkg::out_t             due_hashes[$];
        int                        mismatches;

        function new();
            seed_q     = mm2_pkg::SEED_RESET;
            fold_q     = 1'b1;
            mismatches = 0;
            close_string();
        endfunction

        function void close_string();
            acc    = '0;
            pend   = '0;
            slot   = '0;
            count  = '0;
            in_str = 1'b0;
        endfunction

        function void write_reg(logic index, logic [31:0] value);
            if (index == mm2_pkg::CFG_SEED) begin
                seed_q = value;
            end else begin
                fold_q = value[0];
            end
        endfunction

        function int outstanding();
            return due_hashes.size();
        endfunction

        function void note_byte(mm2_pkg::in_t it);
            logic [7:0]    b;
            logic [31:0]   k;
            logic [31:0]   h;
            mm2_pkg::out_t res;

            // hash seeded from the length on the opening byte
            if (!in_str) begin
                acc    = seed_q ^ 32'(it.total_length);
                pend   = '0;
                slot   = '0;
                count  = '0;
                in_str = 1'b1;
            end
            b = it.data_byte;
            if (fold_q && b >= 8'h41 && b <= 8'h5A) b = b + 8'h20;
            if (count != mm2_pkg::COUNT_MAX) count = count + 1'b1;

            if (slot == 2'd3) begin
                k    = {b, pend};
                k    = k * mm2_pkg::MIX_MUL;
                k    = k ^ (k >> mm2_pkg::MIX_SHIFT);
                k    = k * mm2_pkg::MIX_MUL;
                acc  = (acc * mm2_pkg::MIX_MUL) ^ k;
                pend = '0;
                slot = '0;
            end else begin
                pend = pend | (24'(b) << (8 * slot));
                slot = slot + 1'b1;
            end

            if (!it.last_byte) return;

            h = acc;
            if (slot != 2'd0) begin
                h = h ^ {8'h00, pend};
                h = h * mm2_pkg::MIX_MUL;
            end
            h = h ^ (h >> mm2_pkg::FIN_SHIFT_A);
            h = h * mm2_pkg::MIX_MUL;
            h = h ^ (h >> mm2_pkg::FIN_SHIFT_B);
            res.hash_value   = h;
            // the check takes the length on the final byte
            res.length_error = (count != it.total_length) || (it.total_length == 0)
                               || (it.total_length > MAX_LEN);
            due_hashes.insert(due_hashes.size(), res);
            close_string();
        endfunction

        function void check_hash(mm2_pkg::out_t got);
            mm2_pkg::out_t want;

            if (due_hashes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing due: hash %h err %b",
                             $realtime, got.hash_value, got.length_error);
                return;
            end
            want = due_hashes.pop_front();
            if (got.hash_value !== want.hash_value || got.length_error !== want.length_error) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch: hash exp %h got %h, err exp %b got %b",
                             $realtime, want.hash_value, got.hash_value,
                             want.length_error, got.length_error);
            end
        endfunction
    endclass

    localparam int SETTLE      = 16;    // cycles left after the last result before a cfg write
    localparam int STALL_LIMIT = 4000;  // cycles without any transfer before giving up
    localparam int PHASE_BYTES = 180;   // minimum random bytes per random phase

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          s_valid   = 1'b0;
    logic          s_ready;
    mm2_pkg::in_t  s_data    = '0;
    logic          m_valid;
    logic          m_ready   = 1'b0;
    mm2_pkg::out_t m_data;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic          cfg_index = mm2_pkg::CFG_SEED;
    logic [31:0]   cfg_data  = '0;

    hash_ledger  ledger    = new();
    logic [7:0]  text[$];              // bytes of the string about to be sent
    bit          burst_mode = 1'b0;    // no gaps and no back-pressure while set
    int          ready_hold = 0;
    int          idle_cycles = 0;

    always #10 aclk = ~aclk;

    murmur2_string_hash dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ---------------------------------------------------------------------------------------
    // Monitors. All sampling happens just after the rising edge, before any NBA of that edge
    // lands, so every handshake is seen with its pre-edge values.
    // ---------------------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) ledger.note_byte(s_data);
        if (aresetn && m_valid && m_ready) ledger.check_hash(m_data);
        if (aresetn && cfg_valid && cfg_ready) ledger.write_reg(cfg_index, cfg_data);
    end

    // Result side back-pressure: ready runs of random length broken by stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_hold <= 0;
        end else if (burst_mode) begin
            m_ready <= 1'b1;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (m_ready && $urandom_range(0, 1) == 0) begin
            m_ready    <= 1'b0;
            ready_hold <= pick_gap();
        end else begin
            m_ready    <= 1'b1;
            ready_hold <= $urandom_range(0, 15);
        end
    end

    // Watchdog: a hung handshake anywhere ends the run.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Drivers. Each task is entered just after an edge; valid is only lowered when a gap
    // follows, so back-to-back transfers keep it high with a single NBA per step.
    // ---------------------------------------------------------------------------------------
    task automatic send_byte(input mm2_pkg::in_t item);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Send the bytes in text; the opening byte carries len_first, the rest len_rest.
    task automatic send_text(input logic [mm2_pkg::LEN_W-1:0] len_first,
                             input logic [mm2_pkg::LEN_W-1:0] len_rest);
        mm2_pkg::in_t item;
        for (int i = 0; i < text.size(); i++) begin
            item.data_byte    = text[i];
            item.total_length = (i == 0) ? len_first : len_rest;
            item.last_byte    = (i == text.size() - 1);
            send_byte(item);
        end
    endtask

    // Drop valid and wait for every due result, then a few more cycles.
    task automatic hold_until_drained(input int extra);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (ledger.outstanding() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_settings(input logic [31:0] seed_val, input logic fold_val);
        cfg_valid <= 1'b1;
        cfg_index <= mm2_pkg::CFG_SEED;
        cfg_data  <= seed_val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= mm2_pkg::CFG_FOLD;
        cfg_data  <= {31'b0, fold_val};
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic void load_text(input string s);
        text.delete();
        for (int i = 0; i < s.len(); i++) text.insert(text.size(), s[i]);
    endfunction

    // Random content: full byte range, or a letter-heavy mix to work the case folding.
    function automatic void fill_text(input int n);
        bit         letters;
        logic [7:0] c;
        letters = $urandom_range(0, 1);
        text.delete();
        for (int i = 0; i < n; i++) begin
            if (!letters) begin
                c = 8'($urandom_range(0, 255));
            end else begin
                case ($urandom_range(0, 3))
                    0: c = 8'h41 + 8'($urandom_range(0, 25));
                    1: c = 8'h61 + 8'($urandom_range(0, 25));
                    2: c = 8'h40 + 8'($urandom_range(0, 1)) * 8'h1B;
                    default: c = 8'($urandom_range(0, 255));
                endcase
            end
            text.insert(text.size(), c);
        end
    endfunction

    // One random string: mostly well formed, some with a bad or shifting declared length.
    task automatic send_random_string(output int n);
        int                        r;
        logic [mm2_pkg::LEN_W-1:0] len_first;
        logic [mm2_pkg::LEN_W-1:0] len_rest;

        r = $urandom_range(0, 99);
        if (r < 85)      n = $urandom_range(1, 12);
        else if (r < 97) n = $urandom_range(13, 64);
        else             n = $urandom_range(65, 300);
        fill_text(n);
        len_first = mm2_pkg::LEN_W'(n);
        len_rest  = mm2_pkg::LEN_W'(n);
        r = $urandom_range(0, 99);
        if (r >= 94) begin
            // off by one either way
            len_first = mm2_pkg::LEN_W'(n + 1 - 2 * $urandom_range(0, 1));
            len_rest  = len_first;
        end else if (r >= 88) begin
            // length shifts mid-string
            len_first = mm2_pkg::LEN_W'($urandom_range(0, 8191));
        end else if (r >= 80) begin
            // arbitrary declared length
            len_first = mm2_pkg::LEN_W'($urandom_range(0, 8191));
            len_rest  = len_first;
        end
        send_text(len_first, len_rest);
    endtask

    task automatic random_phase(input logic [31:0] seed_val, input logic fold_val);
        int sent;
        int n;
        write_settings(seed_val, fold_val);
        sent = 0;
        while (sent < PHASE_BYTES) begin
            // back off now and then until the hasher has emptied out
            if ($urandom_range(0, 99) < 5) hold_until_drained(0);
            send_random_string(n);
            sent += n;
        end
        hold_until_drained(SETTLE);
    endtask

    // ---------------------------------------------------------------------------------------
    // Sequence: directed strings on reset settings, then random phases over several settings.
    // ---------------------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // tails of one, two and three bytes, a bare word, folding at the letter boundaries
        load_text("A");     send_text(13'd1, 13'd1);
        load_text("aZ");    send_text(13'd2, 13'd2);
        load_text("@[Z");   send_text(13'd3, 13'd3);
        load_text("AbCd");  send_text(13'd4, 13'd4);
        load_text("Hello"); send_text(13'd5, 13'd5);
        text = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F};
        send_text(13'd6, 13'd6);
        // zero and out-of-range declared lengths, a short count, a length shifting mid-string
        load_text("x");     send_text(13'd0, 13'd0);
        load_text("q");     send_text(13'd8191, 13'd8191);
        load_text("ab");    send_text(13'd3, 13'd3);
        load_text("abc");   send_text(13'd5, 13'd3);
        hold_until_drained(SETTLE);

        random_phase(32'h0000_0000, 1'b0);
        random_phase(32'hFFFF_FFFF, 1'b1);
        burst_mode = 1'b1;
        random_phase($urandom, 1'b0);
        burst_mode = 1'b0;
        random_phase($urandom, 1'b1);
        random_phase($urandom, 1'($urandom_range(0, 1)));

        if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* files.f */
design/mm2_pkg.sv
design/mm2_mul.sv
design/murmur2_string_hash.sv
tb/tb_top.sv
